>>> sv/lfps_pkg.sv
package lfps_pkg;

  // Sensor array and field widths.
  localparam int NUM_SENSORS = 8;
  localparam int IN_W        = 8;
  localparam int DUTY_W      = 10;
  localparam int GAIN_W      = 8;
  localparam int ERR_W       = 4;
  localparam int DUTY_MAX    = 1000;
  localparam int ERR_MAX     = 7;
  localparam int ERR_MIN     = -8;

  // Weight sum bounds: each half contributes at most 1 + 2 + ... + NUM_SENSORS/2.
  localparam int HALF     = NUM_SENSORS / 2;
  localparam int SUM_MAX  = (HALF * (HALF + 1)) / 2;
  localparam int SUM_W    = $clog2(SUM_MAX + 1) + 1;
  localparam int MAG_W    = SUM_W - 1;
  localparam int CNT_W    = $clog2(NUM_SENSORS + 1);

  // Divider: two quotient bits per cycle.
  localparam int DIV_STEPS = (MAG_W + 1) / 2;
  localparam int DVD_W     = 2 * DIV_STEPS;
  localparam int REM_W     = CNT_W + 1;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Correction datapath.
  localparam int DIFF_W = ERR_W + 1;
  localparam int PROD_W = GAIN_W + 1 + DIFF_W;
  localparam int CORR_W = PROD_W + 1;
  localparam int ACC_W  = CORR_W + 2;

  // Stream and configuration port widths.
  localparam int OUT_DATA_W = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Sample queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_FAST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_SLOW = 3'd4;

  // Register reset values.
  localparam logic [DUTY_W-1:0] BASE_DUTY_RST   = 10'd900;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 8'd16;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 8'd16;
  localparam logic [DUTY_W-1:0] SEARCH_FAST_RST = 10'd1000;
  localparam logic [DUTY_W-1:0] SEARCH_SLOW_RST = 10'd200;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRACK  = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_STOP   = 2'd2
  } mode_e;

  // One classified sample as it waits in the queue.
  typedef struct packed {
    mode_e                   mode;
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
  } item_t;

  // One configuration write.
  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Weight of sensor i: -HALF..-1 in the lower half, 1..HALF in the upper half.
  function automatic logic signed [SUM_W-1:0] weight_of(input int i);
    int w;
    w = (i < HALF) ? (i - HALF) : (i - HALF + 1);
    return SUM_W'(w);
  endfunction

endpackage

>>> sv/lfps_front.sv
module lfps_front (
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [lfps_pkg::IN_W-1:0] s_axis_tdata,
  output logic                   push_o,
  output lfps_pkg::item_t        item_o,
  input  logic                   full_i
);

  logic [lfps_pkg::CNT_W-1:0]        count;
  logic signed [lfps_pkg::SUM_W-1:0] sum;

  // Sensors beyond the input width read as dark.
  always_comb begin
    count = '0;
    sum   = '0;
    for (int i = 0; i < lfps_pkg::NUM_SENSORS; i++) begin
      if (i < lfps_pkg::IN_W) begin
        if (s_axis_tdata[i]) begin
          count = count + 1'b1;
          sum   = sum + lfps_pkg::weight_of(i);
        end
      end
    end
  end

  always_comb begin
    item_o.count = count;
    item_o.sum   = sum;
    if (count == '0) begin
      item_o.mode = lfps_pkg::MODE_SEARCH;
    end else if (count == lfps_pkg::CNT_W'(lfps_pkg::NUM_SENSORS)) begin
      item_o.mode = lfps_pkg::MODE_STOP;
    end else begin
      item_o.mode = lfps_pkg::MODE_TRACK;
    end
  end

  assign s_axis_tready = ~full_i;
  assign push_o        = s_axis_tvalid & ~full_i;

endmodule

>>> sv/lfps_fifo.sv
module lfps_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lfps_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lfps_pkg::item_t item_o
);

  lfps_pkg::item_t                mem_q [lfps_pkg::QDEPTH];
  logic [lfps_pkg::QPTR_W-1:0]    wr_ptr_q;
  logic [lfps_pkg::QPTR_W-1:0]    rd_ptr_q;
  logic [lfps_pkg::QCNT_W-1:0]    count_q;

  assign full_o  = (count_q == lfps_pkg::QCNT_W'(lfps_pkg::QDEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> sv/lfps_back.sv
module lfps_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lfps_pkg::cfg_wr_t                 cfg_i,
  input  logic                              q_valid_i,
  input  lfps_pkg::item_t                   q_item_i,
  output logic                              pop_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lfps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [lfps_pkg::MODE_W-1:0]       m_axis_tuser
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [lfps_pkg::DUTY_W-1:0] base_duty_q;
  logic [lfps_pkg::GAIN_W-1:0] prop_gain_q;
  logic [lfps_pkg::GAIN_W-1:0] deriv_gain_q;
  logic [lfps_pkg::DUTY_W-1:0] search_fast_q;
  logic [lfps_pkg::DUTY_W-1:0] search_slow_q;

  logic signed [lfps_pkg::ERR_W-1:0] last_err_q;

  // Divider state.
  logic [lfps_pkg::DVD_W-1:0]  dvd_q;
  logic [lfps_pkg::DVD_W-1:0]  quo_q;
  logic [lfps_pkg::REM_W-1:0]  rem_q;
  logic [lfps_pkg::CNT_W-1:0]  div_q;
  logic                        neg_q;
  logic [lfps_pkg::STEP_W-1:0] step_q;

  // Product stage.
  logic signed [lfps_pkg::ERR_W-1:0]  err_q;
  logic signed [lfps_pkg::PROD_W-1:0] pp_q;
  logic signed [lfps_pkg::PROD_W-1:0] pd_q;

  // Output register.
  logic                        out_valid_q;
  logic                        out_valid_d;
  logic [lfps_pkg::DUTY_W-1:0] left_q;
  logic [lfps_pkg::DUTY_W-1:0] right_q;
  logic                        drive_q;
  lfps_pkg::mode_e             mode_q;
  logic [lfps_pkg::ERR_W-1:0]  line_err_q;

  logic [lfps_pkg::DVD_W-1:0]  dvd_d;
  logic [lfps_pkg::DVD_W-1:0]  quo_d;
  logic [lfps_pkg::REM_W-1:0]  rem_d;

  logic signed [lfps_pkg::DVD_W:0]    quo_s;
  logic signed [lfps_pkg::DVD_W:0]    quo_v;
  logic signed [lfps_pkg::ERR_W-1:0]  err_d;
  logic signed [lfps_pkg::DIFF_W-1:0] diff;
  logic signed [lfps_pkg::CORR_W-1:0] corr;
  logic signed [lfps_pkg::CORR_W-1:0] corr_b;
  logic signed [lfps_pkg::CORR_W-1:0] k;
  logic signed [lfps_pkg::ACC_W-1:0]  base_s;
  logic signed [lfps_pkg::ACC_W-1:0]  left_acc;
  logic signed [lfps_pkg::ACC_W-1:0]  right_acc;
  logic [lfps_pkg::MAG_W-1:0]         mag;
  logic                               out_free;

  function automatic logic [lfps_pkg::DUTY_W-1:0] sat_reg(
    input logic [lfps_pkg::DUTY_W-1:0] v
  );
    return (v > lfps_pkg::DUTY_W'(lfps_pkg::DUTY_MAX)) ?
           lfps_pkg::DUTY_W'(lfps_pkg::DUTY_MAX) : v;
  endfunction

  function automatic logic [lfps_pkg::DUTY_W-1:0] sat_acc(
    input logic signed [lfps_pkg::ACC_W-1:0] v
  );
    logic [lfps_pkg::DUTY_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > lfps_pkg::ACC_W'(lfps_pkg::DUTY_MAX)) begin
      r = lfps_pkg::DUTY_W'(lfps_pkg::DUTY_MAX);
    end else begin
      r = v[lfps_pkg::DUTY_W-1:0];
    end
    return r;
  endfunction

  assign out_free = ~out_valid_q | m_axis_tready;
  assign pop_o    = (state_q == ST_IDLE) & q_valid_i & out_free;

  // The output register is loaded by a search or stop sample leaving the
  // queue, or by the last step of a tracking sample; otherwise it empties
  // when the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q & ~m_axis_tready;
    if (pop_o && (q_item_i.mode != lfps_pkg::MODE_TRACK)) begin
      out_valid_d = 1'b1;
    end
    if (state_q == ST_FIN) begin
      out_valid_d = 1'b1;
    end
  end

  assign mag = q_item_i.sum[lfps_pkg::SUM_W-1] ?
               lfps_pkg::MAG_W'(-q_item_i.sum) : lfps_pkg::MAG_W'(q_item_i.sum);

  // Two restoring division steps per cycle on the magnitude of the sum.
  always_comb begin
    dvd_d = dvd_q;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int j = 0; j < 2; j++) begin
      rem_d = {rem_d[lfps_pkg::REM_W-2:0], dvd_d[lfps_pkg::DVD_W-1]};
      dvd_d = {dvd_d[lfps_pkg::DVD_W-2:0], 1'b0};
      if (rem_d >= {1'b0, div_q}) begin
        rem_d = rem_d - {1'b0, div_q};
        quo_d = {quo_d[lfps_pkg::DVD_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[lfps_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  // Signed, clamped error and its difference from the stored error.
  always_comb begin
    quo_s = signed'({1'b0, quo_q});
    quo_v = neg_q ? -quo_s : quo_s;
    if (quo_v > (lfps_pkg::DVD_W + 1)'(lfps_pkg::ERR_MAX)) begin
      err_d = lfps_pkg::ERR_W'(lfps_pkg::ERR_MAX);
    end else if (quo_v < (lfps_pkg::DVD_W + 1)'(lfps_pkg::ERR_MIN)) begin
      err_d = lfps_pkg::ERR_W'(lfps_pkg::ERR_MIN);
    end else begin
      err_d = lfps_pkg::ERR_W'(quo_v);
    end
    diff = lfps_pkg::DIFF_W'(err_d) - lfps_pkg::DIFF_W'(last_err_q);
  end

  // Correction truncated toward zero, then applied to the base duty.
  always_comb begin
    corr      = lfps_pkg::CORR_W'(pp_q) + lfps_pkg::CORR_W'(pd_q);
    corr_b    = corr + (corr[lfps_pkg::CORR_W-1] ? lfps_pkg::CORR_W'(15) : '0);
    k         = corr_b >>> 4;
    base_s    = signed'(lfps_pkg::ACC_W'(base_duty_q));
    left_acc  = base_s + lfps_pkg::ACC_W'(k);
    right_acc = base_s - lfps_pkg::ACC_W'(k);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_duty_q   <= lfps_pkg::BASE_DUTY_RST;
      prop_gain_q   <= lfps_pkg::PROP_GAIN_RST;
      deriv_gain_q  <= lfps_pkg::DERIV_GAIN_RST;
      search_fast_q <= lfps_pkg::SEARCH_FAST_RST;
      search_slow_q <= lfps_pkg::SEARCH_SLOW_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lfps_pkg::CFG_BASE_DUTY:   base_duty_q   <= cfg_i.data;
        lfps_pkg::CFG_PROP_GAIN:   prop_gain_q   <= cfg_i.data[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_i.data[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::CFG_SEARCH_FAST: search_fast_q <= cfg_i.data;
        lfps_pkg::CFG_SEARCH_SLOW: search_slow_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_err_q  <= '0;
      step_q      <= '0;
      dvd_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      neg_q       <= 1'b0;
      err_q       <= '0;
      pp_q        <= '0;
      pd_q        <= '0;
      left_q      <= '0;
      right_q     <= '0;
      drive_q     <= 1'b0;
      mode_q      <= lfps_pkg::MODE_TRACK;
      line_err_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            case (q_item_i.mode)
              lfps_pkg::MODE_SEARCH: begin
                if (last_err_q > 0) begin
                  left_q  <= sat_reg(search_fast_q);
                  right_q <= sat_reg(search_slow_q);
                end else begin
                  left_q  <= sat_reg(search_slow_q);
                  right_q <= sat_reg(search_fast_q);
                end
                drive_q     <= 1'b1;
                mode_q      <= lfps_pkg::MODE_SEARCH;
                line_err_q  <= last_err_q;
              end
              lfps_pkg::MODE_STOP: begin
                left_q      <= '0;
                right_q     <= '0;
                drive_q     <= 1'b0;
                mode_q      <= lfps_pkg::MODE_STOP;
                line_err_q  <= last_err_q;
              end
              default: begin
                dvd_q   <= lfps_pkg::DVD_W'(mag);
                quo_q   <= '0;
                rem_q   <= '0;
                div_q   <= q_item_i.count;
                neg_q   <= q_item_i.sum[lfps_pkg::SUM_W-1];
                step_q  <= '0;
                state_q <= ST_DIV;
              end
            endcase
          end
        end
        ST_DIV: begin
          dvd_q  <= dvd_d;
          quo_q  <= quo_d;
          rem_q  <= rem_d;
          step_q <= step_q + 1'b1;
          if (step_q == lfps_pkg::STEP_W'(lfps_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          err_q   <= err_d;
          pp_q    <= signed'(lfps_pkg::PROD_W'({1'b0, prop_gain_q})) *
                     lfps_pkg::PROD_W'(err_d);
          pd_q    <= signed'(lfps_pkg::PROD_W'({1'b0, deriv_gain_q})) *
                     lfps_pkg::PROD_W'(diff);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          left_q      <= sat_acc(left_acc);
          right_q     <= sat_acc(right_acc);
          drive_q     <= 1'b1;
          mode_q      <= lfps_pkg::MODE_TRACK;
          line_err_q  <= err_q;
          last_err_q  <= err_q;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = mode_q;
  assign m_axis_tdata  = {
    {(lfps_pkg::OUT_DATA_W - 2 * lfps_pkg::DUTY_W - 1 - lfps_pkg::ERR_W){1'b0}},
    line_err_q, drive_q, right_q, left_q
  };

endmodule

>>> sv/line_follow_pd_steering_top.sv
// PD line-follower steering. Each input transaction carries one 8-bit sensor
// sample (bit i is sensor i, 1 means the sensor sees the white line) and
// produces exactly one output transaction with the left and right motor duties.
// Sensors carry weights -4..-1 and 1..4 from bit 0 up. When some but not all
// sensors are white the block tracks: the error is the weight sum divided by
// the white count, truncated toward zero, and the correction (gains in Q4.4)
// prop_gain*error + deriv_gain*(error - previous error), truncated toward zero
// after dropping four fraction bits, is added to base_duty on the left and
// subtracted on the right, both saturated to 0..1000. With no white sensor the
// block searches, turning toward the sign of the stored error with the
// search_fast and search_slow duties; with all sensors white it stops and
// drops drive_on. A tracking sample goes through the back end from the head of
// the queue to the output register in steps: loading the divider, division at
// two quotient bits per cycle, the two gain multiplies, and the final add and
// saturation. Search and stop samples reach the output register directly as
// they leave the queue. The front end classifies a sample in the cycle it is
// accepted and parks it in a two-entry queue, so input transactions keep
// flowing while a result waits on the output. Configuration writes are taken
// in every cycle and should be issued only while no sample is in flight.
module line_follow_pd_steering_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Sample input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lfps_pkg::IN_W-1:0]         s_axis_tdata,  // [7:0] sensor_bits
  // Result output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [9:0] left_duty, [19:10] right_duty, [20] drive_on, [24:21] line_error,
  // [31:25] zero
  output logic [lfps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [lfps_pkg::MODE_W-1:0]       m_axis_tuser,  // [1:0] mode
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic              push;
  logic              full;
  logic              pop;
  logic              q_valid;
  lfps_pkg::item_t   front_item;
  lfps_pkg::item_t   q_item;
  lfps_pkg::cfg_wr_t cfg_wr;

  // The register file never stalls a write.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  lfps_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .item_o        (front_item),
    .full_i        (full)
  );

  lfps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  lfps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_wr),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> sv/lfps_checker.sv
module lfps_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lfps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [lfps_pkg::MODE_W-1:0]     m_axis_tuser
);

  // A stopped result has zero duties and the drive off.
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == lfps_pkg::MODE_STOP) |->
      (m_axis_tdata[20:0] == 21'd0))
    else $error("stop result with nonzero duty or drive");

  // Tracking and searching results always drive the motors.
  a_drive_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == lfps_pkg::MODE_TRACK ||
                       m_axis_tuser == lfps_pkg::MODE_SEARCH)) |->
      m_axis_tdata[20])
    else $error("moving result with drive off");

  // Both duties stay saturated.
  a_duty_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[9:0] <= 10'd1000 && m_axis_tdata[19:10] <= 10'd1000))
    else $error("duty above saturation limit");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind line_follow_pd_steering_top lfps_checker u_lfps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape. Twelve configured phases of random samples follow a short
  // directed phase that runs on the reset register values.
  localparam int NUM_PHASES       = 12;
  localparam int SAMPLES_PER_PHASE = 165;
  localparam int HOLD_PHASE       = 3;
  localparam int HOLD_CYCLES      = 400;
  localparam int SETTLE_CYCLES    = 12;
  localparam int GAIN_ONE         = 16;  // 1.0 in Q4.4

  // Highest register index on the write channel; everything above
  // CFG_SEARCH_SLOW is unmapped and must leave the registers unchanged.
  localparam int CFG_IDX_TOP = (1 << lfps_pkg::CFG_IDX_W) - 1;

  // Directed samples. The order matters because the stored error carries
  // from one sample to the next: lost-line searches are placed after a
  // negative, a positive and a zero error so both turn directions are seen,
  // and a stop is placed where it must keep a nonzero stored error.
  localparam int NUM_DIRECTED = 22;
  localparam logic [lfps_pkg::IN_W-1:0] DIRECTED_SAMPLES [NUM_DIRECTED] = '{
    8'h00, 8'hFF, 8'h01, 8'h00, 8'h80, 8'h00, 8'h18, 8'h0F,
    8'hF0, 8'h7F, 8'hFE, 8'h03, 8'hC0, 8'hFF, 8'h00, 8'h81,
    8'h55, 8'hAA, 8'h07, 8'hE0, 8'h11, 8'h88
  };

  // One expected output transaction, field by field.
  typedef struct packed {
    logic [lfps_pkg::DUTY_W-1:0]       left;
    logic [lfps_pkg::DUTY_W-1:0]       right;
    logic                              drive;
    lfps_pkg::mode_e                   mode;
    logic signed [lfps_pkg::ERR_W-1:0] err;
  } steer_result_t;

  // Clock, reset and every input of the block start at known values.
  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [lfps_pkg::IN_W-1:0]       s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [lfps_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [lfps_pkg::MODE_W-1:0]     m_axis_tuser;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [lfps_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  line_follow_pd_steering_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Shadow copy of the block's registers and its stored error. The shadow
  // registers change only when a configuration transaction completes.
  logic [lfps_pkg::DUTY_W-1:0] base_duty   = lfps_pkg::BASE_DUTY_RST;
  logic [lfps_pkg::GAIN_W-1:0] prop_gain   = lfps_pkg::PROP_GAIN_RST;
  logic [lfps_pkg::GAIN_W-1:0] deriv_gain  = lfps_pkg::DERIV_GAIN_RST;
  logic [lfps_pkg::DUTY_W-1:0] search_fast = lfps_pkg::SEARCH_FAST_RST;
  logic [lfps_pkg::DUTY_W-1:0] search_slow = lfps_pkg::SEARCH_SLOW_RST;
  int                          stored_error = 0;

  // Samples waiting to be offered, and duties predicted for accepted samples
  // in the order the block must return them.
  logic [lfps_pkg::IN_W-1:0] pending_samples[$];
  steer_result_t             expected_duties[$];

  int  mismatches   = 0;
  bit  sample_taken = 1'b0;  // set at the edge where the input transaction completes
  bit  src_gaps_on  = 1'b1;
  bit  snk_gaps_on  = 1'b1;
  bit  hold_req     = 1'b0;
  bit  hold_off     = 1'b0;
  int  src_wait     = 0;
  int  snk_wait     = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run. The slowest correct run is well under 1.5 ms:
  // about 2000 samples, each behind a sender gap, a receiver stall and the
  // back end, plus one long hold-off and the register writes between phases.
  initial begin
    #5_000_000;
    $display("line_follow_pd_steering_top regression: fail");
    $finish;
  end

  // Gap lengths: mostly back to back, often a short gap, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random samples lean toward what a real sensor bar sees: a narrow run of
  // one to three white sensors somewhere across the bar. The rest are lost
  // line, all white and arbitrary patterns.
  function automatic logic [lfps_pkg::IN_W-1:0] make_sample();
    int          r;
    int          run_len;
    int          run_pos;
    logic [15:0] run;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      run_len = $urandom_range(1, 3);
      run_pos = $urandom_range(0, lfps_pkg::NUM_SENSORS - 1);
      run = ((16'd1 << run_len) - 16'd1) << run_pos;
      return run[lfps_pkg::IN_W-1:0];
    end
    if (r < 60) return '0;
    if (r < 65) return '1;
    return lfps_pkg::IN_W'($urandom());
  endfunction

  function automatic logic [lfps_pkg::DUTY_W-1:0] clip_duty(input int v);
    if (v < 0) return '0;
    if (v > lfps_pkg::DUTY_MAX) return lfps_pkg::DUTY_W'(lfps_pkg::DUTY_MAX);
    return v[lfps_pkg::DUTY_W-1:0];
  endfunction

  // Steering law for one sample. Updates the stored error on tracking
  // samples only; searching and stopping keep it.
  function automatic steer_result_t steer_predict(input logic [lfps_pkg::IN_W-1:0] bits);
    steer_result_t r;
    int white;
    int wsum;
    int err;
    int diff;
    int corr;
    int k;
    white = 0;
    wsum  = 0;
    for (int i = 0; i < lfps_pkg::NUM_SENSORS; i++) begin
      if (bits[i]) begin
        white++;
        // Lower half weighs -HALF..-1, upper half 1..HALF; there is no zero.
        wsum += (i < lfps_pkg::NUM_SENSORS / 2) ? i - lfps_pkg::NUM_SENSORS / 2 :
                                                  i - lfps_pkg::NUM_SENSORS / 2 + 1;
      end
    end
    if (white == 0) begin
      // Lost line: turn toward the side where the line was last seen.
      r.mode  = lfps_pkg::MODE_SEARCH;
      r.drive = 1'b1;
      if (stored_error > 0) begin
        r.left  = clip_duty(int'(search_fast));
        r.right = clip_duty(int'(search_slow));
      end else begin
        r.left  = clip_duty(int'(search_slow));
        r.right = clip_duty(int'(search_fast));
      end
    end else if (white == lfps_pkg::NUM_SENSORS) begin
      r.mode  = lfps_pkg::MODE_STOP;
      r.drive = 1'b0;
      r.left  = '0;
      r.right = '0;
    end else begin
      // Integer division truncates toward zero, as the block does.
      err = wsum / white;
      if (err > lfps_pkg::ERR_MAX) err = lfps_pkg::ERR_MAX;
      if (err < lfps_pkg::ERR_MIN) err = lfps_pkg::ERR_MIN;
      diff = err - stored_error;
      corr = int'(prop_gain) * err + int'(deriv_gain) * diff;
      k    = corr / GAIN_ONE;
      r.mode  = lfps_pkg::MODE_TRACK;
      r.drive = 1'b1;
      r.left  = clip_duty(int'(base_duty) + k);
      r.right = clip_duty(int'(base_duty) - k);
      stored_error = err;
    end
    r.err = lfps_pkg::ERR_W'(stored_error);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
               $signed(want), $signed(got));
    end
  endtask

  // Sample driver. Inputs change on the falling edge only. A new sample is
  // put up once the previous one has been taken, possibly after a gap; the
  // valid never drops while a sample is still waiting to be taken.
  always @(negedge clk_i) begin
    if (rst_ni && (sample_taken || !s_axis_tvalid)) begin
      sample_taken = 1'b0;
      if (src_wait > 0) begin
        src_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        s_axis_tdata  <= pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        src_wait = src_gaps_on ? pick_gap() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver. Ready is dropped for random stalls, and held low for
  // the whole of a long hold-off when one is running.
  always @(negedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (snk_wait > 0) begin
      snk_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      snk_wait = snk_gaps_on ? pick_gap() : 0;
    end
  end

  // Long hold-off, counted in its own process on the rising edge. While it
  // runs the sender keeps offering samples back to back, so the two-entry
  // queue and the output register fill and the block must stall its input.
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Monitor and scoreboard on the rising edge. The output transaction is
  // checked before the input transaction of the same edge is recorded; a
  // sample's result can never leave in the cycle the sample is taken.
  always @(posedge clk_i) begin : scoreboard
    steer_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_duties.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_duties.pop_front();
          check_field("left_duty", 32'(want.left), 32'(m_axis_tdata[9:0]));
          check_field("right_duty", 32'(want.right), 32'(m_axis_tdata[19:10]));
          check_field("drive_on", 32'(want.drive), 32'(m_axis_tdata[20]));
          check_field("mode", 32'(want.mode), 32'(m_axis_tuser));
          check_field("line_error", 32'(want.err),
                      32'($signed(m_axis_tdata[24:21])));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_duties.push_back(steer_predict(s_axis_tdata));
        sample_taken = 1'b1;
      end
    end
  end

  // One register write. The shadow copy follows the write at the edge where
  // the transaction completes; unmapped indexes change nothing.
  task automatic write_reg(input logic [lfps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lfps_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      lfps_pkg::CFG_BASE_DUTY:   base_duty   = val[lfps_pkg::DUTY_W-1:0];
      lfps_pkg::CFG_PROP_GAIN:   prop_gain   = val[lfps_pkg::GAIN_W-1:0];
      lfps_pkg::CFG_DERIV_GAIN:  deriv_gain  = val[lfps_pkg::GAIN_W-1:0];
      lfps_pkg::CFG_SEARCH_FAST: search_fast = val[lfps_pkg::DUTY_W-1:0];
      lfps_pkg::CFG_SEARCH_SLOW: search_slow = val[lfps_pkg::DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [lfps_pkg::CFG_DATA_W-1:0] base,
                           input logic [lfps_pkg::CFG_DATA_W-1:0] pgain,
                           input logic [lfps_pkg::CFG_DATA_W-1:0] dgain,
                           input logic [lfps_pkg::CFG_DATA_W-1:0] fast,
                           input logic [lfps_pkg::CFG_DATA_W-1:0] slow);
    write_reg(lfps_pkg::CFG_BASE_DUTY, base);
    write_reg(lfps_pkg::CFG_PROP_GAIN, pgain);
    write_reg(lfps_pkg::CFG_DERIV_GAIN, dgain);
    write_reg(lfps_pkg::CFG_SEARCH_FAST, fast);
    write_reg(lfps_pkg::CFG_SEARCH_SLOW, slow);
  endtask

  // Waits until every queued sample has been taken and every predicted
  // result has come back, then lets the back end settle before anything
  // else touches the registers.
  task automatic wait_drain();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_duties.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    // Reset is asserted once and released on a falling edge so it never
    // coincides with a sampling edge.
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed phase on the reset register values.
    for (int i = 0; i < NUM_DIRECTED; i++) pending_samples.push_back(DIRECTED_SAMPLES[i]);
    wait_drain();

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      // Some phases run with no idling on one side or the other.
      src_gaps_on = (phase % 3 != 0) && (phase != HOLD_PHASE);
      snk_gaps_on = (phase % 4 != 1);
      case (phase)
        // Everything at zero: duties pinned low, no correction at all.
        1: write_all('0, '0, '0, '0, '0);
        // Every data bit set: duties above 1000 must saturate, and the gain
        // registers keep only their low eight bits.
        2: write_all('1, '1, '1, '1, '1);
        // Full gains around the top duty, searching between 1000 and 0.
        3: write_all(10'd1000, 10'd255, 10'd255, 10'd1000, 10'd0);
        // Low base with a strong proportional term drives one side to clip at zero.
        4: write_all(10'd0, 10'd255, 10'd0, 10'd0, 10'd1000);
        default: write_all(lfps_pkg::CFG_DATA_W'($urandom()),
                           lfps_pkg::CFG_DATA_W'($urandom()),
                           lfps_pkg::CFG_DATA_W'($urandom()),
                           lfps_pkg::CFG_DATA_W'($urandom()),
                           lfps_pkg::CFG_DATA_W'($urandom()));
      endcase
      // A write to an unmapped index must be ignored.
      if (phase % 2 == 0)
        write_reg(lfps_pkg::CFG_IDX_W'($urandom_range(int'(lfps_pkg::CFG_SEARCH_SLOW) + 1,
                                                       CFG_IDX_TOP)),
                  lfps_pkg::CFG_DATA_W'($urandom()));

      @(posedge clk_i);
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      for (int n = 0; n < SAMPLES_PER_PHASE; n++) pending_samples.push_back(make_sample());
      wait_drain();
    end

    if (mismatches == 0) begin
      $display("line_follow_pd_steering_top regression: pass");
    end else begin
      $display("line_follow_pd_steering_top regression: fail");
    end
    $finish;
  end

endmodule
